// ===== sv/uri_percent_encoder_unit_macros.svh =====
// assertion macros shared by the uri percent encoder modules
`ifndef URI_PERCENT_ENCODER_UNIT_MACROS_SVH
`define URI_PERCENT_ENCODER_UNIT_MACROS_SVH

// condition implies consequence in the same cycle
`define UPE_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("uri percent encoder assertion failed");

// condition implies consequence in the next cycle
`define UPE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("uri percent encoder assertion failed");

`endif

// ===== sv/uripe_pkg.sv =====
// types, constants and helper functions of the uri percent encoder
package uripe_pkg;

   localparam int QUEUE_DEPTH_DEFAULT = 4;
   localparam int CSR_ADDR_WIDTH = 3;
   localparam int CSR_DATA_WIDTH = 32;
   localparam logic CSR_MODE_INDEX = 1'b0;

   localparam logic [1:0] MODE_ESCAPE = 2'd0;
   localparam logic [1:0] MODE_URI = 2'd1;
   localparam logic [1:0] MODE_COMPONENT = 2'd2;

   localparam logic [6:0] CHAR_PERCENT = 7'h25;
   localparam logic [6:0] CHAR_LOWER_U = 7'h75;
   localparam logic [6:0] CHAR_NUL = 7'h00;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_payload_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       run_last;
      logic       uri_error;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      JOB_CHAR,
      JOB_PCT,
      JOB_UESC,
      JOB_ERR
   } job_kind_type;

   // bytes[0] goes out first, but for JOB_UESC, where bytes[1] (the high byte) goes out first
   typedef struct packed {
      job_kind_type    kind;
      logic [1:0]      last_byte;
      logic [3:0][7:0] bytes;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] hex_char(input logic [3:0] d);
      logic [6:0] c;
      if (d < 4'd10) begin
         c = 7'h30 + {3'b000, d};
      end else begin
         c = 7'h37 + {3'b000, d};
      end
      return c;
   endfunction

   function automatic logic is_alnum(input logic [15:0] u);
      return (u >= 16'h0041 && u <= 16'h005A) || (u >= 16'h0061 && u <= 16'h007A) ||
             (u >= 16'h0030 && u <= 16'h0039);
   endfunction

   // @*_+-./
   function automatic logic is_escape_mark(input logic [15:0] u);
      logic r;
      case (u)
         16'h0040, 16'h002A, 16'h005F, 16'h002B, 16'h002D, 16'h002E, 16'h002F: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // -_.!~*'()
   function automatic logic is_unreserved_mark(input logic [15:0] u);
      logic r;
      case (u)
         16'h002D, 16'h005F, 16'h002E, 16'h0021, 16'h007E,
         16'h002A, 16'h0027, 16'h0028, 16'h0029: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

   // ;/?:@&=+$, and #
   function automatic logic is_reserved_mark(input logic [15:0] u);
      logic r;
      case (u)
         16'h003B, 16'h002F, 16'h003F, 16'h003A, 16'h0040, 16'h0026,
         16'h003D, 16'h002B, 16'h0024, 16'h002C, 16'h0023: r = 1'b1;
         default: r = 1'b0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/uripe_queue.sv =====
// job queue between the classifier and the character expander
`include "uri_percent_encoder_unit_macros.svh"

module uripe_queue #(
   parameter int DEPTH = uripe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push,
   input  uripe_pkg::job_type            push_job,
   input  logic                          pop,
   output uripe_pkg::job_type            head_job,
   output uripe_pkg::queue_status_type   status
);
   import uripe_pkg::*;

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_job;
      end
   end

   assign head_job     = mem[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);

   `UPE_ASSERT_IMP(q_no_overflow, clock, reset, push, !status.full)
   `UPE_ASSERT_IMP(q_no_underflow, clock, reset, pop, !status.empty)
   `UPE_ASSERT_NEXT(q_count_steady, clock, reset, push && pop, count_ff == $past(count_ff))

endmodule

// ===== sv/uripe_front.sv =====
// input classifier: surrogate tracking, error and drop handling, job building
module uripe_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [1:0]                 mode,
   input  logic                       req_valid,
   input  uripe_pkg::req_payload_type req_payload,
   input  logic                       queue_full,
   output logic                       req_stall,
   output logic                       push,
   output uripe_pkg::job_type         job
);
   import uripe_pkg::*;

   logic [9:0] held_bits_ff, held_bits_in;
   logic       held_ff, held_in;
   logic       drop_ff, drop_in;

   logic [15:0] u;
   logic        last;
   logic        accept;
   logic        is_low;
   logic        is_high;
   logic        pass_uri;
   logic [4:0]  plane;

   assign u       = req_payload.code_unit;
   assign last    = req_payload.last_unit;
   assign accept  = req_valid && !queue_full;
   assign is_low  = (u[15:10] == 6'b110111);
   assign is_high = (u[15:10] == 6'b110110);
   assign plane   = {1'b0, held_bits_ff[9:6]} + 5'd1;
   assign pass_uri = is_alnum(u) || is_unreserved_mark(u) ||
                     ((mode == MODE_URI) && is_reserved_mark(u));
   assign req_stall = queue_full;

   always_comb begin
      held_bits_in  = held_bits_ff;
      held_in       = held_ff;
      drop_in       = drop_ff;
      push          = 1'b0;
      job.kind      = JOB_CHAR;
      job.last_byte = 2'd0;
      job.bytes     = '0;
      if (drop_ff) begin
         held_in      = 1'b0;
         held_bits_in = '0;
         if (last) begin
            drop_in = 1'b0;
         end
      end else if (held_ff) begin
         held_in      = 1'b0;
         held_bits_in = '0;
         push         = 1'b1;
         if (mode == MODE_ESCAPE || !is_low) begin
            job.kind = JOB_ERR;
            drop_in  = !last;
         end else begin
            job.kind      = JOB_PCT;
            job.last_byte = 2'd3;
            job.bytes[0]  = {5'b11110, plane[4:2]};
            job.bytes[1]  = {2'b10, plane[1:0], held_bits_ff[5:2]};
            job.bytes[2]  = {2'b10, held_bits_ff[1:0], u[9:6]};
            job.bytes[3]  = {2'b10, u[5:0]};
         end
      end else if (mode == MODE_ESCAPE) begin
         push = 1'b1;
         if (is_alnum(u) || is_escape_mark(u)) begin
            job.bytes[0] = u[7:0];
         end else if (u[15:8] != 8'd0) begin
            job.kind     = JOB_UESC;
            job.bytes[0] = u[7:0];
            job.bytes[1] = u[15:8];
         end else begin
            job.kind     = JOB_PCT;
            job.bytes[0] = u[7:0];
         end
      end else begin
         push = 1'b1;
         if (pass_uri) begin
            job.bytes[0] = u[7:0];
         end else if (is_low) begin
            job.kind = JOB_ERR;
            drop_in  = !last;
         end else if (is_high) begin
            if (last) begin
               job.kind = JOB_ERR;
            end else begin
               push         = 1'b0;
               held_in      = 1'b1;
               held_bits_in = u[9:0];
            end
         end else if (u[15:7] == 9'd0) begin
            job.kind     = JOB_PCT;
            job.bytes[0] = u[7:0];
         end else if (u[15:11] == 5'd0) begin
            job.kind      = JOB_PCT;
            job.last_byte = 2'd1;
            job.bytes[0]  = {3'b110, u[10:6]};
            job.bytes[1]  = {2'b10, u[5:0]};
         end else begin
            job.kind      = JOB_PCT;
            job.last_byte = 2'd2;
            job.bytes[0]  = {4'b1110, u[15:12]};
            job.bytes[1]  = {2'b10, u[11:6]};
            job.bytes[2]  = {2'b10, u[5:0]};
         end
      end
      if (!accept) begin
         push         = 1'b0;
         held_in      = held_ff;
         held_bits_in = held_bits_ff;
         drop_in      = drop_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff      <= 1'b0;
         drop_ff      <= 1'b0;
         held_bits_ff <= '0;
      end else begin
         held_ff      <= held_in;
         drop_ff      <= drop_in;
         held_bits_ff <= held_bits_in;
      end
   end

endmodule

// ===== sv/uripe_back.sv =====
// character expander: turns queued jobs into one output character per cycle unless rsp_stall holds it
`include "uri_percent_encoder_unit_macros.svh"

module uripe_back (
   input  logic                        clock,
   input  logic                        reset,
   input  uripe_pkg::job_type          head_job,
   input  uripe_pkg::queue_status_type status,
   output logic                        pop,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output uripe_pkg::rsp_payload_type  rsp_payload
);
   import uripe_pkg::*;

   logic [2:0]      phase_ff, phase_in;
   logic [1:0]      idx_ff, idx_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   logic            advance;
   logic [7:0]      cur_byte;
   logic [6:0]      ch;
   logic            ch_last;
   logic            ch_err;

   assign advance  = !rsp_valid_ff || !rsp_stall;
   assign cur_byte = head_job.bytes[idx_ff];

   always_comb begin
      ch      = CHAR_NUL;
      ch_last = 1'b0;
      ch_err  = 1'b0;
      case (head_job.kind)
         JOB_CHAR: begin
            ch      = head_job.bytes[0][6:0];
            ch_last = 1'b1;
         end
         JOB_ERR: begin
            ch_last = 1'b1;
            ch_err  = 1'b1;
         end
         JOB_PCT: begin
            case (phase_ff)
               3'd0:    ch = CHAR_PERCENT;
               3'd1:    ch = hex_char(cur_byte[7:4]);
               default: ch = hex_char(cur_byte[3:0]);
            endcase
            ch_last = (phase_ff == 3'd2) && (idx_ff == head_job.last_byte);
         end
         default: begin
            // %uHHHH, high byte first
            case (phase_ff)
               3'd0:    ch = CHAR_PERCENT;
               3'd1:    ch = CHAR_LOWER_U;
               3'd2:    ch = hex_char(head_job.bytes[1][7:4]);
               3'd3:    ch = hex_char(head_job.bytes[1][3:0]);
               3'd4:    ch = hex_char(head_job.bytes[0][7:4]);
               default: ch = hex_char(head_job.bytes[0][3:0]);
            endcase
            ch_last = (phase_ff == 3'd5);
         end
      endcase
   end

   always_comb begin
      phase_in       = phase_ff;
      idx_in         = idx_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_payload_in = rsp_payload_ff;
      pop            = 1'b0;
      if (advance) begin
         rsp_valid_in = !status.empty;
         if (!status.empty) begin
            rsp_payload_in.out_char  = ch;
            rsp_payload_in.run_last  = ch_last;
            rsp_payload_in.uri_error = ch_err;
            if (ch_last) begin
               pop      = 1'b1;
               phase_in = '0;
               idx_in   = '0;
            end else if (head_job.kind == JOB_PCT && phase_ff == 3'd2) begin
               phase_in = '0;
               idx_in   = idx_ff + 1'b1;
            end else begin
               phase_in = phase_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_payload_ff <= rsp_payload_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `UPE_ASSERT_IMP(b_err_form, clock, reset, rsp_valid_ff && rsp_payload_ff.uri_error, rsp_payload_ff.run_last && rsp_payload_ff.out_char == CHAR_NUL)
   `UPE_ASSERT_NEXT(b_counters_rewind, clock, reset, pop, phase_ff == 3'd0 && idx_ff == 2'd0)
   `UPE_ASSERT_IMP(b_byte_in_range, clock, reset, !status.empty && head_job.kind == JOB_PCT, idx_ff <= head_job.last_byte)

endmodule

// ===== sv/uri_percent_encoder_unit.sv =====
// Streaming escape / encodeURI / encodeURIComponent encoder. One UTF-16 code unit is taken
// per cycle while the job queue (QUEUE_DEPTH entries) has room; each unit that yields output
// becomes one queued job, and the expander sends its characters one per cycle unless rsp_stall
// holds them. A job has 1 character for a passed character or an error word, 3 for %XX, 6 for
// %uXXXX, 6 or 9 for two- or three-byte UTF-8, 12 for a surrogate pair. A held high surrogate
// or a dropped unit is taken and yields nothing. The expander's one-character-per-cycle output
// register sets the sustained rate. encoding_mode sits at byte address 0 of the APB port:
// 0 escape, 1 full URI, 2 or 3 URI component; write it only while the block is idle.
module uri_percent_encoder_unit #(
   parameter int QUEUE_DEPTH = uripe_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  uripe_pkg::req_payload_type           req_payload,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output uripe_pkg::rsp_payload_type           rsp_payload,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [uripe_pkg::CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [uripe_pkg::CSR_DATA_WIDTH-1:0] pwdata,
   output logic [uripe_pkg::CSR_DATA_WIDTH-1:0] prdata,
   output logic                                 pready
);
   import uripe_pkg::*;

   logic [1:0]       mode_ff, mode_in;
   logic             push;
   logic             pop;
   job_type          push_job;
   job_type          head_job;
   queue_status_type status;

   assign pready = 1'b1;

   always_comb begin
      mode_in = mode_ff;
      if (psel && penable && pwrite && paddr[2] == CSR_MODE_INDEX) begin
         mode_in = pwdata[1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ESCAPE;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign prdata = (paddr[2] == CSR_MODE_INDEX) ? {{(CSR_DATA_WIDTH - 2){1'b0}}, mode_ff} : '0;

   uripe_front u_front (
      .clock       (clock),
      .reset       (reset),
      .mode        (mode_ff),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .queue_full  (status.full),
      .req_stall   (req_stall),
      .push        (push),
      .job         (push_job)
   );

   uripe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   uripe_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_job    (head_job),
      .status      (status),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
